@@ design/dtpcg_pkg.sv @@
// shared types, constants and the default pattern table for the clock pattern generator
package dtpcg_pkg;

	localparam int TABLE_DEPTH_DEF = 128;

	localparam int DEFAULT_WORDS = 82;
	localparam logic [15:0] WORD_EVEN = 16'd65522;
	localparam logic [15:0] WORD_ODD = 16'd65514;
	localparam logic [15:0] WORD_AT5 = 16'd65506;
	localparam logic [15:0] WORD_AT6 = 16'd65488;
	localparam logic [15:0] WORD_AT41 = 16'd65517;

	localparam logic [7:0] RESET_PATTERN_LENGTH = 8'd82;
	localparam logic [16:0] RESET_DEBOUNCE_TICKS = 17'd6000;
	localparam logic [15:0] RESET_START_RELOAD = 16'd1000;

	localparam logic [16:0] FULL_COUNT = 17'h10000;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_RELOAD = 2'd2;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef struct packed {
		op_t operation;
		logic button_level;
		logic [6:0] entry_index;
		logic [15:0] entry_value;
	} item_t;

	// table contents after reset
	function automatic logic [15:0] default_word(input logic [31:0] pos);
		logic [15:0] w;
		if (pos >= 32'(DEFAULT_WORDS)) begin
			w = 16'd0;
		end else if (pos == 32'd5) begin
			w = WORD_AT5;
		end else if (pos == 32'd6) begin
			w = WORD_AT6;
		end else if (pos == 32'd41) begin
			w = WORD_AT41;
		end else if (pos[0]) begin
			w = WORD_ODD;
		end else begin
			w = WORD_EVEN;
		end
		return w;
	endfunction

endpackage

@@ design/dtpcg_ram.sv @@
// generic single-port-write ram with registered read
module dtpcg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/dtpcg_mod.sv @@
// iterative remainder unit, one quotient bit per cycle
module dtpcg_mod #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] result
);

	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     dvd_q;
	logic [W-1:0]     dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [W:0]       trial;
	logic [W-1:0]     rem_nxt;

	always_comb begin
		trial = {rem_q, dvd_q[W-1]};
		if (trial >= {1'b0, dvs_q}) begin
			rem_nxt = W'(trial - {1'b0, dvs_q});
		end else begin
			rem_nxt = trial[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dvd_q <= {dvd_q[W-2:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign done = busy_q && (cnt_q == CNT_W'(1));
	assign result = rem_nxt;

endmodule

@@ design/dtpcg_debounce.sv @@
// button debounce timer and press event detection
module dtpcg_debounce (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tick,
	input  logic        pressed,
	input  logic [16:0] debounce_ticks,
	output logic        press_event
);

	logic [16:0] cnt_q, cnt_d;
	logic        busy_q, busy_d;
	logic        done_q, done_d;
	logic        held_q, held_d;

	always_comb begin
		cnt_d = cnt_q;
		busy_d = busy_q;
		done_d = done_q;
		held_d = held_q;
		press_event = 1'b0;
		if (tick) begin
			if (busy_q) begin
				if (cnt_q > 17'd1) begin
					cnt_d = cnt_q - 17'd1;
				end else begin
					cnt_d = '0;
					busy_d = 1'b0;
					done_d = 1'b1;
				end
			end
			if (pressed) begin
				if (done_d) begin
					held_d = 1'b1;
				end else if (!busy_d) begin
					cnt_d = (debounce_ticks == '0) ? 17'd1 : debounce_ticks;
					busy_d = 1'b1;
				end
			end else begin
				done_d = 1'b0;
				if (held_q) begin
					held_d = 1'b0;
					press_event = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			held_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			busy_q <= busy_d;
			done_q <= done_d;
			held_q <= held_d;
		end
	end

endmodule

@@ design/dtpcg_gen.sv @@
// pattern generator: period countdown, pattern index, table storage
module dtpcg_gen #(
	parameter int TABLE_DEPTH = dtpcg_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tick,
	input  logic               wr,
	input  dtpcg_pkg::item_t   item,
	input  logic               press_event,
	input  logic [7:0]         pattern_length,
	input  logic [15:0]        start_reload,
	input  logic               len_load,
	input  logic [7:0]         len_new,
	output logic               clock_level,
	output logic               running,
	output logic               busy
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int LEN_W = $clog2(TABLE_DEPTH + 1);

	function automatic logic [LEN_W-1:0] used_len_f(input logic [7:0] l);
		logic [LEN_W-1:0] r;
		if (l == 8'd0) begin
			r = LEN_W'(1);
		end else if (32'(l) > 32'(TABLE_DEPTH)) begin
			r = LEN_W'(TABLE_DEPTH);
		end else begin
			r = LEN_W'(l);
		end
		return r;
	endfunction

	logic [16:0]      cnt_q, cnt_d;
	logic             clk_q, clk_d;
	logic             act_q, act_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [IDX_W-1:0] nxt_q, nxt_d;
	logic [LEN_W-1:0] used_len;

	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [15:0]      ram_rdata;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [IDX_W-1:0] rd_addr_q;
	logic             rd_valid_q;
	logic             byp_q;
	logic [15:0]      byp_data_q;
	logic [15:0]      word;

	logic             mod_done;
	logic [LEN_W-1:0] mod_result;

	assign used_len = used_len_f(pattern_length);

	// word at the current index; rd_addr_q always tracks idx_q
	always_comb begin
		if (byp_q) begin
			word = byp_data_q;
		end else if (rd_valid_q) begin
			word = ram_rdata;
		end else begin
			word = dtpcg_pkg::default_word(32'(rd_addr_q));
		end
	end

	assign waddr = IDX_W'(item.entry_index);
	assign we = wr && !act_q && (32'(item.entry_index) < 32'(TABLE_DEPTH));

	always_comb begin
		cnt_d = cnt_q;
		clk_d = clk_q;
		act_d = act_q;
		idx_d = idx_q;
		nxt_d = nxt_q;
		if (tick && act_q) begin
			if (cnt_q > 17'd1) begin
				cnt_d = cnt_q - 17'd1;
			end else begin
				clk_d = !clk_q;
				cnt_d = dtpcg_pkg::FULL_COUNT - {1'b0, word};
				idx_d = nxt_q;
				if ((LEN_W'(nxt_q) + LEN_W'(1)) == used_len) begin
					nxt_d = '0;
				end else begin
					nxt_d = nxt_q + IDX_W'(1);
				end
			end
		end
		if (tick && press_event) begin
			if (act_q) begin
				act_d = 1'b0;
				clk_d = 1'b0;
				idx_d = '0;
				cnt_d = '0;
				nxt_d = (used_len == LEN_W'(1)) ? '0 : IDX_W'(1);
			end else begin
				act_d = 1'b1;
				cnt_d = dtpcg_pkg::FULL_COUNT - {1'b0, start_reload};
			end
		end
		if (mod_done) begin
			nxt_d = IDX_W'(mod_result);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			clk_q <= 1'b0;
			act_q <= 1'b0;
			idx_q <= '0;
			nxt_q <= IDX_W'(1);
			valid_q <= '0;
			rd_addr_q <= '0;
			rd_valid_q <= 1'b0;
			byp_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			clk_q <= clk_d;
			act_q <= act_d;
			idx_q <= idx_d;
			nxt_q <= nxt_d;
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rd_addr_q <= idx_d;
			rd_valid_q <= valid_q[idx_d];
			byp_q <= we && (waddr == idx_d);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= item.entry_value;
	end

	dtpcg_ram #(
		.WIDTH(16),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(item.entry_value),
		.raddr(idx_d),
		.rdata(ram_rdata)
	);

	// next index after a length change: (index + 1) mod length
	dtpcg_mod #(
		.W(LEN_W)
	) u_mod (
		.clk(clk),
		.arst_n(arst_n),
		.start(len_load),
		.dividend(LEN_W'(idx_q) + LEN_W'(1)),
		.divisor(used_len_f(len_new)),
		.busy(busy),
		.done(mod_done),
		.result(mod_result)
	);

	assign clock_level = clk_d;
	assign running = act_d;

endmodule

@@ design/debounced_toggle_pattern_clock_gen_unit.sv @@
// top level of the debounced toggle pattern clock generator
//
// usage: every input transfer on s_* is one item; s_tuser is the operation
// (0 = one timer tick, 1 = write one pattern table word, taken only while
// the generator is stopped). every item gives exactly one result transfer on
// m_* holding the clock level, the running flag and the press event flag.
// configuration registers are written through cfg_* (0 pattern length,
// 1 debounce ticks, 2 start reload) while no item is in flight.
// each item passes the input register and then the result register before
// its result shows on m_*; one item is taken every cycle while the receiver
// takes results and no remainder run is busy, since the work for an item is
// short logic between the input register and the result register.
// writing pattern length starts a remainder unit that re-wraps the index;
// while it runs, s_tready and cfg_ready stay low.
// reset clears all control state; the table reads back its default words
// until an entry is written. when the receiver stalls, the result register
// holds, the input register fills and then s_tready drops.
module debounced_toggle_pattern_clock_gen_unit #(
	parameter int TABLE_DEPTH = dtpcg_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // button_level, entry_index[6:0], entry_value[15:0]
	input  logic        s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // clock_level, running, press_event, zero padding
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [dtpcg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dtpcg_pkg::CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [7:0]  pattern_length_q;
	logic [16:0] debounce_ticks_q;
	logic [15:0] start_reload_q;

	// input stage and result register
	logic              valid_s1;
	dtpcg_pkg::item_t  item_s1;
	logic              out_valid_q;
	logic [2:0]        out_data_q;

	logic adv;
	logic process;
	logic tick;
	logic wr;
	logic cfg_wr;
	logic busy;
	logic press_event;
	logic clock_level;
	logic running;

	assign adv = !out_valid_q || m_tready;
	assign process = valid_s1 && adv;
	assign tick = process && (item_s1.operation == dtpcg_pkg::OP_TICK);
	assign wr = process && (item_s1.operation == dtpcg_pkg::OP_WRITE);

	// input register refills in the same cycle it drains
	assign s_tready = (!valid_s1 || adv) && !busy;
	assign cfg_ready = !busy;
	assign cfg_wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= dtpcg_pkg::RESET_PATTERN_LENGTH;
			debounce_ticks_q <= dtpcg_pkg::RESET_DEBOUNCE_TICKS;
			start_reload_q <= dtpcg_pkg::RESET_START_RELOAD;
		end else if (cfg_wr) begin
			case (cfg_index)
				dtpcg_pkg::CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data[7:0];
				dtpcg_pkg::CFG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_data[16:0];
				dtpcg_pkg::CFG_START_RELOAD: start_reload_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (process) begin
				valid_s1 <= 1'b0;
			end
			if (process) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.operation <= dtpcg_pkg::op_t'(s_tuser);
			item_s1.button_level <= s_tdata[0];
			item_s1.entry_index <= s_tdata[7:1];
			item_s1.entry_value <= s_tdata[23:8];
		end
		if (process) begin
			out_data_q <= {press_event, running, clock_level};
		end
	end

	dtpcg_debounce u_debounce (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick),
		.pressed(!item_s1.button_level),
		.debounce_ticks(debounce_ticks_q),
		.press_event(press_event)
	);

	dtpcg_gen #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_gen (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick),
		.wr(wr),
		.item(item_s1),
		.press_event(press_event),
		.pattern_length(pattern_length_q),
		.start_reload(start_reload_q),
		.len_load(cfg_wr && (cfg_index == dtpcg_pkg::CFG_PATTERN_LENGTH)),
		.len_new(cfg_data[7:0]),
		.clock_level(clock_level),
		.running(running),
		.busy(busy)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata = {5'b0, out_data_q};

endmodule

@@ sim/debounced_toggle_pattern_clock_gen_unit_tb.sv @@
// self-checking testbench for the debounced toggle pattern clock generator unit
module debounced_toggle_pattern_clock_gen_unit_tb;

	localparam int CLOCK_CYCLE = 8;
	localparam int CYCLE_LIMIT = 20_000;
	localparam int STALL_CYCLES = 64;
	localparam int MAX_REPORTS = 10;
	localparam logic [dtpcg_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic BTN_DOWN = 1'b0;
	localparam logic BTN_UP = 1'b1;

	typedef struct packed {
		logic clock_level;
		logic running;
		logic press_event;
	} pin_state_t;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [23:0]                      s_tdata;   // button_level, entry_index[6:0], entry_value[15:0]
	logic                             s_tuser;   // operation
	logic                             m_tvalid;
	logic                             m_tready;
	logic [7:0]                       m_tdata;   // clock_level, running, press_event, zero padding
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [dtpcg_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dtpcg_pkg::CFG_DATA_W-1:0] cfg_data;

	// mirror of the generator state, updated once per accepted transfer
	logic [15:0] gen_table [dtpcg_pkg::TABLE_DEPTH_DEF];
	logic [6:0]  gen_index;
	logic [16:0] period_left;
	logic        clk_level;
	logic        gen_on;
	logic [16:0] debounce_left;
	logic        debounce_running;
	logic        debounce_met;
	logic        press_latched;
	logic [7:0]  pattern_len;
	logic [16:0] debounce_len;
	logic [15:0] first_reload;

	pin_state_t pins_due [$];
	int mismatches = 0;
	int cycle_count = 0;
	int send_idle_pct = 11;
	int recv_idle_pct = 11;
	bit stall_req = 1'b0;

	debounced_toggle_pattern_clock_gen_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLOCK_CYCLE / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	// expected pins after one item: debounce timer, then generator, then button, then toggle
	function automatic pin_state_t predict_pins(input dtpcg_pkg::op_t op, input logic btn,
		input logic [6:0] ix, input logic [15:0] val);
		pin_state_t p;
		int wrap;
		p.press_event = 1'b0;
		if (op == dtpcg_pkg::OP_WRITE) begin
			if (!gen_on) gen_table[ix] = val;
		end else begin
			if (debounce_running) begin
				if (debounce_left > 17'd1) begin
					debounce_left = debounce_left - 17'd1;
				end else begin
					debounce_left = '0;
					debounce_running = 1'b0;
					debounce_met = 1'b1;
				end
			end
			if (gen_on) begin
				if (period_left > 17'd1) begin
					period_left = period_left - 17'd1;
				end else begin
					clk_level = ~clk_level;
					if (pattern_len == 8'd0)
						wrap = 1;
					else if (int'(pattern_len) > dtpcg_pkg::TABLE_DEPTH_DEF)
						wrap = dtpcg_pkg::TABLE_DEPTH_DEF;
					else
						wrap = int'(pattern_len);
					period_left = dtpcg_pkg::FULL_COUNT - {1'b0, gen_table[gen_index]};
					gen_index = 7'((int'(gen_index) + 1) % wrap);
				end
			end
			if (btn == BTN_DOWN) begin
				if (debounce_met) begin
					press_latched = 1'b1;
				end else if (!debounce_running) begin
					debounce_left = (debounce_len == '0) ? 17'd1 : debounce_len;
					debounce_running = 1'b1;
				end
			end else begin
				debounce_met = 1'b0;
				if (press_latched) begin
					press_latched = 1'b0;
					p.press_event = 1'b1;
				end
			end
			if (p.press_event) begin
				if (gen_on) begin
					gen_on = 1'b0;
					clk_level = 1'b0;
					gen_index = '0;
					period_left = '0;
				end else begin
					period_left = dtpcg_pkg::FULL_COUNT - {1'b0, first_reload};
					gen_on = 1'b1;
				end
			end
		end
		p.clock_level = clk_level;
		p.running = gen_on;
		return p;
	endfunction

	// receiver: random idling, plus a long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (stall_req) begin
				stall_req = 1'b0;
				stall_left = STALL_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// every result transfer is compared with the oldest expectation
	always @(posedge clk) begin
		pin_state_t got;
		pin_state_t want;
		if (m_tvalid && m_tready) begin
			got.clock_level = m_tdata[0];
			got.running = m_tdata[1];
			got.press_event = m_tdata[2];
			if (pins_due.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("cycle %0d: result %b%b%b with nothing expected",
						cycle_count, got.clock_level, got.running, got.press_event);
				mismatches++;
			end else begin
				want = pins_due.pop_front();
				if (got != want) begin
					if (mismatches < MAX_REPORTS)
						$display("cycle %0d: clock/running/press expected %b%b%b seen %b%b%b",
							cycle_count, want.clock_level, want.running, want.press_event,
							got.clock_level, got.running, got.press_event);
					mismatches++;
				end
			end
		end
	end

	task automatic send_item(input dtpcg_pkg::op_t op, input logic btn, input logic [6:0] ix,
		input logic [15:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {val, ix, btn};
		do @(posedge clk); while (!s_tready);
		pins_due.push_back(predict_pins(op, btn, ix, val));
	endtask

	task automatic send_tick(input logic btn);
		send_item(dtpcg_pkg::OP_TICK, btn, 7'($urandom_range(127)),
			16'($urandom_range(65535)));
	endtask

	task automatic run_ticks(input int n);
		repeat (n) send_tick(BTN_UP);
	endtask

	task automatic press_release(input int hold, input int rel);
		repeat (hold) send_tick(BTN_DOWN);
		repeat (rel) send_tick(BTN_UP);
	endtask

	task automatic write_entry(input logic [6:0] ix, input logic [15:0] val);
		send_item(dtpcg_pkg::OP_WRITE, 1'($urandom_range(1)), ix, val);
	endtask

	// sender stops until every expected result is back and the block is quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pins_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [dtpcg_pkg::CFG_IDX_W-1:0] idx,
		input logic [dtpcg_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			dtpcg_pkg::CFG_PATTERN_LENGTH: pattern_len = val[7:0];
			dtpcg_pkg::CFG_DEBOUNCE_TICKS: debounce_len = val;
			dtpcg_pkg::CFG_START_RELOAD: first_reload = val[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// reset outputs, then the default table words walked from a short first half period
	task automatic test_reset_defaults();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_ticks(4);
		settle();
		write_reg(dtpcg_pkg::CFG_DEBOUNCE_TICKS, 17'd1);
		write_reg(dtpcg_pkg::CFG_START_RELOAD, 16'hFFFA);
		press_release(2, 1);        // start
		run_ticks(180);
		press_release(2, 1);        // stop
		send_idle_pct = 11;
		recv_idle_pct = 11;
	endtask

	task automatic test_debounce_cases();
		settle();
		write_reg(dtpcg_pkg::CFG_DEBOUNCE_TICKS, 17'd0);   // acts as one tick
		press_release(2, 1);
		run_ticks(5);
		settle();
		write_reg(dtpcg_pkg::CFG_DEBOUNCE_TICKS, 17'd4);
		// release while the timer runs, press again on the tick it expires
		press_release(1, 3);
		press_release(1, 1);
		run_ticks(3);
	endtask

	task automatic test_table_and_length();
		settle();
		write_reg(dtpcg_pkg::CFG_START_RELOAD, 16'hFFFF);
		write_reg(dtpcg_pkg::CFG_PATTERN_LENGTH, 8'd2);
		write_reg(dtpcg_pkg::CFG_DEBOUNCE_TICKS, 17'd2);
		write_entry(7'd0, 16'hFFFF);
		write_entry(7'd1, 16'hFFFE);
		write_entry(7'd127, 16'h0000);
		write_entry(7'd64, 16'h5AA5);
		press_release(3, 1);
		run_ticks(20);
		write_entry(7'd0, 16'h0000);            // dropped while running
		run_ticks(10);
		press_release(3, 1);
		settle();
		write_reg(dtpcg_pkg::CFG_PATTERN_LENGTH, 8'd0);    // acts as one word
		press_release(3, 1);
		run_ticks(10);
		press_release(3, 1);
		settle();
		write_reg(dtpcg_pkg::CFG_PATTERN_LENGTH, 8'd255);  // clamps to the full table
		for (int i = 0; i < dtpcg_pkg::TABLE_DEPTH_DEF; i++)
			write_entry(7'(i), (i == 0) ? 16'd65532 : 16'd65535);
		press_release(3, 1);
		run_ticks(140);
		press_release(3, 1);
	endtask

	// zero start reload and a zero table word both give 65536-tick half periods
	task automatic test_long_periods();
		settle();
		write_reg(dtpcg_pkg::CFG_START_RELOAD, 16'd0);
		write_reg(dtpcg_pkg::CFG_PATTERN_LENGTH, 8'd1);
		write_reg(dtpcg_pkg::CFG_DEBOUNCE_TICKS, 17'd1);
		write_entry(7'd0, 16'd0);
		press_release(2, 1);
		run_ticks(8);
		settle();
		write_reg(dtpcg_pkg::CFG_DEBOUNCE_TICKS, 17'h10000);
		write_reg(CFG_UNUSED, 17'($urandom_range(131071)));
		write_reg(dtpcg_pkg::CFG_DEBOUNCE_TICKS, 17'd1);
		press_release(2, 1);
	endtask

	// long receiver hold-off while items keep coming, then a full drain
	task automatic test_backpressure();
		settle();
		write_reg(dtpcg_pkg::CFG_START_RELOAD, 16'hFFF0);
		press_release(2, 1);
		stall_req = 1'b1;
		repeat (48) send_tick(1'($urandom_range(1)));
		settle();
	endtask

	task automatic test_random_phases();
		int n;
		int roll;
		int hold;
		int rel;
		for (int phase = 0; phase < 4; phase++) begin
			settle();
			case (phase)
				0: write_reg(dtpcg_pkg::CFG_PATTERN_LENGTH, 8'd1);
				1: write_reg(dtpcg_pkg::CFG_PATTERN_LENGTH, 8'd128);
				2: write_reg(dtpcg_pkg::CFG_PATTERN_LENGTH, 8'd3);
				default: write_reg(dtpcg_pkg::CFG_PATTERN_LENGTH, 8'($urandom_range(40, 2)));
			endcase
			write_reg(dtpcg_pkg::CFG_DEBOUNCE_TICKS, 17'($urandom_range(6)));
			write_reg(dtpcg_pkg::CFG_START_RELOAD, 16'(65535 - $urandom_range(15)));
			n = 0;
			while (n < 40) begin
				roll = $urandom_range(99);
				if (roll < 12) begin
					if ($urandom_range(3) == 0)
						write_entry(7'($urandom_range(127)), 16'($urandom_range(65535)));
					else
						write_entry(7'($urandom_range(127)), 16'($urandom_range(65535, 65500)));
					n++;
				end else if (roll < 35) begin
					hold = $urandom_range(int'(debounce_len) + 3, 1);
					rel = $urandom_range(3, 1);
					press_release(hold, rel);
					n += hold + rel;
				end else if (roll < 42) begin
					send_tick(1'($urandom_range(1)));
					n++;
				end else begin
					hold = $urandom_range(8, 1);
					run_ticks(hold);
					n += hold;
				end
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= dtpcg_pkg::OP_TICK;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= dtpcg_pkg::CFG_PATTERN_LENGTH;
		cfg_data <= '0;
		for (int i = 0; i < dtpcg_pkg::TABLE_DEPTH_DEF; i++) begin
			if (i >= dtpcg_pkg::DEFAULT_WORDS) gen_table[i] = '0;
			else if (i == 5) gen_table[i] = dtpcg_pkg::WORD_AT5;
			else if (i == 6) gen_table[i] = dtpcg_pkg::WORD_AT6;
			else if (i == 41) gen_table[i] = dtpcg_pkg::WORD_AT41;
			else if (i % 2 == 1) gen_table[i] = dtpcg_pkg::WORD_ODD;
			else gen_table[i] = dtpcg_pkg::WORD_EVEN;
		end
		gen_index = '0;
		period_left = '0;
		clk_level = 1'b0;
		gen_on = 1'b0;
		debounce_left = '0;
		debounce_running = 1'b0;
		debounce_met = 1'b0;
		press_latched = 1'b0;
		pattern_len = dtpcg_pkg::RESET_PATTERN_LENGTH;
		debounce_len = dtpcg_pkg::RESET_DEBOUNCE_TICKS;
		first_reload = dtpcg_pkg::RESET_START_RELOAD;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_debounce_cases();
		test_table_and_length();
		test_long_periods();
		test_backpressure();
		test_random_phases();

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ debounced_toggle_pattern_clock_gen_unit.f @@
design/dtpcg_pkg.sv
design/dtpcg_ram.sv
design/dtpcg_mod.sv
design/dtpcg_debounce.sv
design/dtpcg_gen.sv
design/debounced_toggle_pattern_clock_gen_unit.sv
sim/debounced_toggle_pattern_clock_gen_unit_tb.sv
